[hw/rtl/lsc_pkg.sv]
package lsc_pkg;

   localparam logic [5:0] K_LPAREN  = 6'd0;
   localparam logic [5:0] K_RPAREN  = 6'd1;
   localparam logic [5:0] K_LBRACE  = 6'd2;
   localparam logic [5:0] K_RBRACE  = 6'd3;
   localparam logic [5:0] K_COMMA   = 6'd4;
   localparam logic [5:0] K_DOT     = 6'd5;
   localparam logic [5:0] K_MINUS   = 6'd6;
   localparam logic [5:0] K_PLUS    = 6'd7;
   localparam logic [5:0] K_SEMI    = 6'd8;
   localparam logic [5:0] K_SLASH   = 6'd9;
   localparam logic [5:0] K_STAR    = 6'd10;
   localparam logic [5:0] K_BANG    = 6'd11;
   localparam logic [5:0] K_EQUAL   = 6'd13;
   localparam logic [5:0] K_GREATER = 6'd15;
   localparam logic [5:0] K_LESS    = 6'd17;
   localparam logic [5:0] K_IDENT   = 6'd19;
   localparam logic [5:0] K_STRING  = 6'd20;
   localparam logic [5:0] K_NUMBER  = 6'd21;
   localparam logic [5:0] K_EOF     = 6'd38;
   localparam logic [5:0] K_ERROR   = 6'd39;

   localparam logic [1:0] E_NONE       = 2'd0;
   localparam logic [1:0] E_UNEXPECTED = 2'd1;
   localparam logic [1:0] E_UNTERM     = 2'd2;

   localparam int WORD_DEPTH  = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int MAX_TOKENS  = 3;

   typedef enum logic [3:0] {
      M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_SLASH, M_LCOMMENT,
      M_BCOMMENT, M_STRING, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_IDENT
   } mode_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [1:0]  err;
   } token_type;

   typedef struct packed {
      logic [1:0]                     count;
      token_type [MAX_TOKENS-1:0]     tok;
   } bundle_type;

   // keywords with their first byte in the low byte
   localparam logic [15:0][47:0] KW_WORD = '{
      48'("elihw"), 48'("rav"), 48'("eurt"), 48'("siht"),
      48'("repus"), 48'("nruter"), 48'("tnirPd"), 48'("ro"),
      48'("lin"), 48'("fi"), 48'("rof"), 48'("nuf"),
      48'("eslaf"), 48'("esle"), 48'("ssalc"), 48'("dna")
   };
   localparam logic [15:0][2:0] KW_LEN = '{
      3'd5, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd2,
      3'd3, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3
   };

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [15:0] sat16(input logic [31:0] v);
      return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [15:0] len);
      logic [47:0] mask;
      logic [5:0]  k;
      mask = '0;
      k = K_IDENT;
      for (int i = 0; i < WORD_DEPTH; i++) begin
         if (16'(i) < len) mask[8*i +: 8] = 8'hFF;
      end
      for (int i = 0; i < 16; i++) begin
         if (len == 16'(KW_LEN[i]) && (w & mask) == KW_WORD[i]) k = 6'(22 + i);
      end
      return k;
   endfunction

   function automatic mode_type idle_mode(input logic [7:0] c);
      mode_type m;
      case (c)
         "!": m = M_BANG;
         "=": m = M_EQUAL;
         "<": m = M_LESS;
         ">": m = M_GREATER;
         "/": m = M_SLASH;
         "\"": m = M_STRING;
         default: begin
            if (is_digit(c)) m = M_NUM_INT;
            else if (is_alpha(c)) m = M_IDENT;
            else m = M_IDLE;
         end
      endcase
      return m;
   endfunction

   // single-byte token started from idle: {emits, kind}
   function automatic logic [6:0] idle_emit(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         "(": r = {1'b1, K_LPAREN};
         ")": r = {1'b1, K_RPAREN};
         "{": r = {1'b1, K_LBRACE};
         "}": r = {1'b1, K_RBRACE};
         ",": r = {1'b1, K_COMMA};
         ".": r = {1'b1, K_DOT};
         "-": r = {1'b1, K_MINUS};
         "+": r = {1'b1, K_PLUS};
         ";": r = {1'b1, K_SEMI};
         "*": r = {1'b1, K_STAR};
         "!", "=", "<", ">", "/", "\"", " ", "\r", "\t", "\n": r = {1'b0, K_IDENT};
         default: begin
            if (is_digit(c) || is_alpha(c)) r = {1'b0, K_IDENT};
            else r = {1'b1, K_ERROR};
         end
      endcase
      return r;
   endfunction

   function automatic logic [5:0] op_kind(input mode_type m);
      logic [5:0] k;
      case (m)
         M_BANG:  k = K_BANG;
         M_EQUAL: k = K_EQUAL;
         M_LESS:  k = K_LESS;
         default: k = K_GREATER;
      endcase
      return k;
   endfunction

endpackage

[hw/rtl/lsc_front.sv]
module lsc_front import lsc_pkg::*; #(
   parameter int POSITION_WIDTH = 16,
   parameter int LINE_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] ch,
   input  logic       eos,
   output bundle_type bundle
);

   localparam logic [POSITION_WIDTH-1:0] POS_MAX  = '1;
   localparam logic [LINE_WIDTH-1:0]     LINE_MAX = '1;

   mode_type                  mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0] start_ff, start_in, offset_ff, offset_in, next_off, dot_pos;
   logic [LINE_WIDTH-1:0]     line_ff, line_in, line_inc;
   logic [47:0]               word_ff, word_in;
   logic [15:0]               wlen_ff, wlen_in;
   logic                      star_ff, star_in;
   logic                      is_op, restart, do_flush;
   logic [6:0]                single;

   function automatic token_type mk(input logic [5:0] k, input logic [POSITION_WIDTH-1:0] s,
                                    input logic [POSITION_WIDTH-1:0] e, input logic [1:0] er);
      token_type t;
      logic [POSITION_WIDTH-1:0] d;
      d = (e >= s) ? e - s : '0;
      t.kind  = k;
      t.start = sat16(32'(s));
      t.len   = sat16(32'(d));
      t.line  = sat16(32'(line_ff));
      t.err   = er;
      return t;
   endfunction

   assign next_off = (offset_ff == POS_MAX) ? offset_ff : offset_ff + 1'b1;
   assign line_inc = (line_ff == LINE_MAX) ? line_ff : line_ff + 1'b1;
   assign dot_pos  = (offset_ff > start_ff) ? offset_ff - 1'b1 : start_ff;
   assign is_op    = mode_ff == M_BANG || mode_ff == M_EQUAL || mode_ff == M_LESS ||
                     mode_ff == M_GREATER;
   assign single   = idle_emit(ch);

   always_comb begin
      case (mode_ff)
         M_IDLE:     restart = 1'b1;
         M_BANG, M_EQUAL, M_LESS, M_GREATER: restart = ch != "=";
         M_SLASH:    restart = ch != "/" && ch != "*";
         M_LCOMMENT: restart = ch == "\n";
         M_NUM_INT:  restart = !is_digit(ch) && ch != ".";
         M_NUM_DOT, M_NUM_FRAC: restart = !is_digit(ch);
         M_IDENT:    restart = !is_digit(ch) && !is_alpha(ch);
         default:    restart = 1'b0;
      endcase
   end

   assign do_flush = eos ? (mode_ff != M_STRING) : restart;

   // next scan mode
   always_comb begin
      mode_in = mode_ff;
      if (fire) begin
         if (eos) begin
            mode_in = M_IDLE;
         end else if (restart) begin
            mode_in = idle_mode(ch);
         end else begin
            case (mode_ff)
               M_BANG, M_EQUAL, M_LESS, M_GREATER: mode_in = M_IDLE;
               M_SLASH:    mode_in = (ch == "/") ? M_LCOMMENT : M_BCOMMENT;
               M_BCOMMENT: if (star_ff && ch == "/") mode_in = M_IDLE;
               M_STRING:   if (ch == "\"") mode_in = M_IDLE;
               M_NUM_INT:  if (ch == ".") mode_in = M_NUM_DOT;
               M_NUM_DOT:  mode_in = M_NUM_FRAC;
               default:    mode_in = mode_ff;
            endcase
         end
      end
   end

   // tokens caused by this byte
   always_comb begin
      logic [1:0] n;
      n = '0;
      bundle = '0;
      if (eos && mode_ff == M_STRING) begin
         bundle.tok[n] = mk(K_ERROR, start_ff, offset_ff, E_UNTERM);
         n = n + 1'b1;
      end
      if (!eos && is_op && ch == "=") begin
         bundle.tok[n] = mk(op_kind(mode_ff) + 6'd1, start_ff, next_off, E_NONE);
         n = n + 1'b1;
      end
      if (!eos && mode_ff == M_STRING && ch == "\"") begin
         bundle.tok[n] = mk(K_STRING, start_ff, next_off, E_NONE);
         n = n + 1'b1;
      end
      if (do_flush) begin
         case (mode_ff)
            M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
               bundle.tok[n] = mk(op_kind(mode_ff), start_ff, offset_ff, E_NONE);
               n = n + 1'b1;
            end
            M_SLASH: begin
               bundle.tok[n] = mk(K_SLASH, start_ff, offset_ff, E_NONE);
               n = n + 1'b1;
            end
            M_NUM_INT, M_NUM_FRAC: begin
               bundle.tok[n] = mk(K_NUMBER, start_ff, offset_ff, E_NONE);
               n = n + 1'b1;
            end
            M_NUM_DOT: begin
               bundle.tok[n] = mk(K_NUMBER, start_ff, dot_pos, E_NONE);
               n = n + 1'b1;
               bundle.tok[n] = mk(K_DOT, dot_pos, offset_ff, E_NONE);
               n = n + 1'b1;
            end
            M_IDENT: begin
               bundle.tok[n] = mk(word_kind(word_ff, wlen_ff), start_ff, offset_ff, E_NONE);
               n = n + 1'b1;
            end
            default: ;
         endcase
      end
      if (eos) begin
         bundle.tok[n] = mk(K_EOF, offset_ff, offset_ff, E_NONE);
         n = n + 1'b1;
      end else if (restart && single[6]) begin
         bundle.tok[n] = mk(single[5:0], offset_ff, next_off,
                            (single[5:0] == K_ERROR) ? E_UNEXPECTED : E_NONE);
         n = n + 1'b1;
      end
      bundle.count = n;
   end

   // position, line and word state
   always_comb begin
      start_in  = start_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      word_in   = word_ff;
      wlen_in   = wlen_ff;
      star_in   = star_ff;
      if (fire) begin
         if (eos) begin
            start_in  = '0;
            offset_in = '0;
            line_in   = LINE_WIDTH'(1);
            wlen_in   = '0;
            star_in   = 1'b0;
         end else begin
            offset_in = next_off;
            if (restart) begin
               start_in = offset_ff;
               if (ch == "\n") line_in = line_inc;
               if (is_alpha(ch)) begin
                  word_in[7:0] = ch;
                  wlen_in      = 16'd1;
               end
            end else begin
               case (mode_ff)
                  M_SLASH: star_in = 1'b0;
                  M_BCOMMENT: begin
                     if (ch == "\n") line_in = line_inc;
                     if (!(star_ff && ch == "/")) star_in = ch == "*";
                  end
                  M_STRING: if (ch == "\n") line_in = line_inc;
                  M_IDENT: begin
                     if (wlen_ff < 16'(WORD_DEPTH)) word_in[8*wlen_ff[2:0] +: 8] = ch;
                     if (wlen_ff != 16'hFFFF) wlen_in = wlen_ff + 16'd1;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         line_ff   <= LINE_WIDTH'(1);
         wlen_ff   <= '0;
         star_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         wlen_ff   <= wlen_in;
         star_ff   <= star_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

[hw/rtl/lsc_queue.sv]
module lsc_queue import lsc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       ready,
   input  logic       pop,
   output logic       valid,
   output bundle_type pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   bundle_type             slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]            cnt_ff, cnt_in;

   assign ready    = cnt_ff != (PW+1)'(QUEUE_DEPTH);
   assign valid    = cnt_ff != '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push && ready) begin
         wr_in  = (wr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         cnt_in = cnt_in + 1'b1;
      end
      if (pop && valid) begin
         rd_in  = (rd_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_in = cnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && ready) slot_ff[wr_ff] <= push_data;
   end

endmodule

[hw/rtl/lsc_back.sv]
module lsc_back import lsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  bundle_type  q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_text_length,
   output logic [15:0] rsp_line_number,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);

   bundle_type hold_ff, hold_in;
   logic       has_ff, has_in;
   logic [1:0] idx_ff, idx_in;
   logic       last, done, take;
   token_type  cur;

   assign cur       = hold_ff.tok[idx_ff];
   assign last      = idx_ff == hold_ff.count - 2'd1;
   assign done      = has_ff && rsp_ready && last;
   assign take      = q_valid && (!has_ff || done);
   assign q_pop     = take;
   assign rsp_valid = has_ff;

   assign rsp_token_kind   = cur.kind;
   assign rsp_start_offset = cur.start;
   assign rsp_text_length  = cur.len;
   assign rsp_line_number  = cur.line;
   assign rsp_error_code   = cur.err;
   assign rsp_last_of_run  = last;

   always_comb begin
      hold_in = hold_ff;
      has_in  = has_ff;
      idx_in  = idx_ff;
      if (take) begin
         hold_in = q_data;
         has_in  = 1'b1;
         idx_in  = '0;
      end else if (done) begin
         has_in  = 1'b0;
      end else if (has_ff && rsp_ready) begin
         idx_in  = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         has_ff <= has_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != E_NONE |-> rsp_token_kind == K_ERROR)
      else $error("error code on a non-error token");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == K_EOF |-> rsp_last_of_run)
      else $error("eof is not the last token of its run");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      has_ff |-> hold_ff.count != 2'd0 && idx_ff < hold_ff.count)
      else $error("token index beyond bundle");

endmodule

[hw/rtl/script_lexer_token_scanner.sv]
// streaming lexical scanner: one source byte per req_ transfer, tokens on rsp_
// req_ch carries a byte; req_end_of_source flushes any pending token, emits
// eof and returns the scanner to its reset state for the next source
// each byte causes zero to three tokens; the last token of a byte has
// rsp_last_of_run set, a byte that causes none produces no transfer
// throughput: one byte per cycle while the result side keeps up; a byte that
// causes k tokens occupies the result port for k transfers
// a byte's tokens pass through the bundle queue and then the output register
// before they appear on rsp_
// the scanner classifies each byte combinationally, one-byte lookahead held as
// scan mode; the back end serializes a bundle at one token per rsp_ready cycle
// reset clears scan mode, offsets, line (to one) and empties the queue
// when rsp_ready is low the output register holds, the queue fills and then
// req_ready drops until room opens up again
module script_lexer_token_scanner import lsc_pkg::*; #(
   parameter int POSITION_WIDTH = 16,
   parameter int LINE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_text_length,
   output logic [15:0] rsp_line_number,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);

   logic       fire, q_ready, q_valid, q_pop;
   bundle_type front_bundle, q_data;

   // a byte is taken whenever the queue has room
   assign req_ready = q_ready;
   assign fire      = req_valid && req_ready;

   lsc_front #(
      .POSITION_WIDTH(POSITION_WIDTH),
      .LINE_WIDTH(LINE_WIDTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .ch     (req_ch),
      .eos    (req_end_of_source),
      .bundle (front_bundle)
   );

   // only bytes that produce tokens enter the queue
   lsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && front_bundle.count != 2'd0),
      .push_data (front_bundle),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   lsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_text_length  (rsp_text_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

[test/tb_script_lexer_token_scanner.sv]
`timescale 1ns / 100ps

module tb_script_lexer_token_scanner;
   import lsc_pkg::*;

   typedef struct {
      logic [7:0] ch;
      bit         eos;
   } src_item_type;

   typedef struct {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [1:0]  err;
      logic        last;
   } exp_token_type;

   localparam int unsigned OFFSET_TOP = 65535;
   localparam int unsigned LINE_TOP   = 65535;
   localparam int WATCHDOG_LIMIT      = 3000;
   localparam int HOLDOFF_CYCLES      = 300;
   localparam int PAUSE_AT            = 250;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_ch;
   logic        req_end_of_source;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_text_length;
   logic [15:0] rsp_line_number;
   logic [1:0]  rsp_error_code;
   logic        rsp_last_of_run;

   script_lexer_token_scanner dut (.*);

   // source bytes waiting to be offered, tokens waiting to come back
   src_item_type  source_q[$];
   exp_token_type token_q[$];

   int fails = 0;
   int bytes_taken = 0;
   int tokens_seen = 0;
   int eof_seen = 0;
   int errors_seen = 0;
   bit byte_taken = 0;
   bit stim_done = 0;

   // ---------------- scanner shadow state ----------------
   mode_type      lex_mode = M_IDLE;
   int unsigned   lex_tok_start = 0;
   int unsigned   lex_offset = 0;
   int unsigned   lex_line = 1;
   logic [7:0]    lex_word[WORD_DEPTH];
   int unsigned   lex_wlen = 0;
   bit            lex_star = 0;
   exp_token_type step_toks[$];

   string keywords[16] = '{"and", "class", "else", "false", "fun", "for", "if", "nil",
      "or", "dPrint", "return", "super", "this", "true", "var", "while"};

   function automatic logic [15:0] cap16(input int unsigned v);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic int unsigned next_off();
      return (lex_offset < OFFSET_TOP) ? lex_offset + 1 : OFFSET_TOP;
   endfunction

   function automatic void add_token(input logic [5:0] kind, input int unsigned s,
                                     input int unsigned e, input logic [1:0] err);
      exp_token_type t;
      t.kind  = kind;
      t.start = cap16(s);
      t.len   = cap16(e >= s ? e - s : 0);
      t.line  = cap16(lex_line);
      t.err   = err;
      t.last  = 1'b0;
      step_toks = {step_toks, t};
   endfunction

   function automatic bit digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit word_ch(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void bump_line();
      if (lex_line < LINE_TOP) lex_line++;
   endfunction

   // keyword lookup; anything longer than the buffer is an identifier
   function automatic logic [5:0] lookup_word();
      string w;
      w = "";
      if (lex_wlen > WORD_DEPTH) return K_IDENT;
      for (int i = 0; i < lex_wlen; i++) w = {w, string'(lex_word[i])};
      for (int i = 0; i < 16; i++) begin
         if (w == keywords[i]) return 6'(22 + i);
      end
      return K_IDENT;
   endfunction

   function automatic logic [5:0] pending_op();
      case (lex_mode)
         M_BANG:  return K_BANG;
         M_EQUAL: return K_EQUAL;
         M_LESS:  return K_LESS;
         default: return K_GREATER;
      endcase
   endfunction

   function automatic void start_byte(input logic [7:0] c);
      lex_tok_start = lex_offset;
      lex_mode = M_IDLE;
      case (c)
         "(": add_token(K_LPAREN, lex_offset, next_off(), E_NONE);
         ")": add_token(K_RPAREN, lex_offset, next_off(), E_NONE);
         "{": add_token(K_LBRACE, lex_offset, next_off(), E_NONE);
         "}": add_token(K_RBRACE, lex_offset, next_off(), E_NONE);
         ",": add_token(K_COMMA, lex_offset, next_off(), E_NONE);
         ".": add_token(K_DOT, lex_offset, next_off(), E_NONE);
         "-": add_token(K_MINUS, lex_offset, next_off(), E_NONE);
         "+": add_token(K_PLUS, lex_offset, next_off(), E_NONE);
         ";": add_token(K_SEMI, lex_offset, next_off(), E_NONE);
         "*": add_token(K_STAR, lex_offset, next_off(), E_NONE);
         "!": lex_mode = M_BANG;
         "=": lex_mode = M_EQUAL;
         "<": lex_mode = M_LESS;
         ">": lex_mode = M_GREATER;
         "/": lex_mode = M_SLASH;
         " ", "\r", "\t": ;
         "\n": bump_line();
         "\"": lex_mode = M_STRING;
         default: begin
            if (digit_ch(c)) lex_mode = M_NUM_INT;
            else if (word_ch(c)) begin
               lex_mode = M_IDENT;
               lex_word[0] = c;
               lex_wlen = 1;
            end else add_token(K_ERROR, lex_offset, next_off(), E_UNEXPECTED);
         end
      endcase
   endfunction

   // pending token ends just before the current offset
   function automatic void flush_token();
      int unsigned dot;
      case (lex_mode)
         M_BANG, M_EQUAL, M_LESS, M_GREATER:
            add_token(pending_op(), lex_tok_start, lex_offset, E_NONE);
         M_SLASH: add_token(K_SLASH, lex_tok_start, lex_offset, E_NONE);
         M_NUM_INT, M_NUM_FRAC: add_token(K_NUMBER, lex_tok_start, lex_offset, E_NONE);
         M_NUM_DOT: begin
            // "1." without a digit: number then a separate dot
            dot = (lex_offset > lex_tok_start) ? lex_offset - 1 : lex_tok_start;
            add_token(K_NUMBER, lex_tok_start, dot, E_NONE);
            add_token(K_DOT, dot, lex_offset, E_NONE);
         end
         M_IDENT: add_token(lookup_word(), lex_tok_start, lex_offset, E_NONE);
         default: ;
      endcase
      lex_mode = M_IDLE;
   endfunction

   function automatic void scan_ch(input logic [7:0] c);
      case (lex_mode)
         M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
            if (c == "=") begin
               add_token(pending_op() + 6'd1, lex_tok_start, next_off(), E_NONE);
               lex_mode = M_IDLE;
            end else begin
               flush_token();
               start_byte(c);
            end
         end
         M_SLASH: begin
            if (c == "/") lex_mode = M_LCOMMENT;
            else if (c == "*") begin
               lex_mode = M_BCOMMENT;
               lex_star = 0;
            end else begin
               flush_token();
               start_byte(c);
            end
         end
         M_LCOMMENT: if (c == "\n") start_byte(c);
         M_BCOMMENT: begin
            if (c == "\n") bump_line();
            if (lex_star && c == "/") lex_mode = M_IDLE;
            else lex_star = (c == "*");
         end
         M_STRING: begin
            if (c == "\n") bump_line();
            if (c == "\"") begin
               add_token(K_STRING, lex_tok_start, next_off(), E_NONE);
               lex_mode = M_IDLE;
            end
         end
         M_NUM_INT: begin
            if (c == ".") lex_mode = M_NUM_DOT;
            else if (!digit_ch(c)) begin
               flush_token();
               start_byte(c);
            end
         end
         M_NUM_DOT: begin
            if (digit_ch(c)) lex_mode = M_NUM_FRAC;
            else begin
               flush_token();
               start_byte(c);
            end
         end
         M_NUM_FRAC: begin
            if (!digit_ch(c)) begin
               flush_token();
               start_byte(c);
            end
         end
         M_IDENT: begin
            if (word_ch(c) || digit_ch(c)) begin
               if (lex_wlen < WORD_DEPTH) lex_word[lex_wlen] = c;
               if (lex_wlen < 65535) lex_wlen++;
            end else begin
               flush_token();
               start_byte(c);
            end
         end
         default: start_byte(c);
      endcase
   endfunction

   // one accepted byte or end marker -> expected tokens
   function automatic void predict_tokens(input logic [7:0] c, input bit eos);
      step_toks.delete();
      if (eos) begin
         if (lex_mode == M_STRING)
            add_token(K_ERROR, lex_tok_start, lex_offset, E_UNTERM);
         else
            flush_token();
         add_token(K_EOF, lex_offset, lex_offset, E_NONE);
         lex_mode = M_IDLE;
         lex_tok_start = 0;
         lex_offset = 0;
         lex_line = 1;
         lex_wlen = 0;
         lex_star = 0;
      end else begin
         scan_ch(c);
         lex_offset = next_off();
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) token_q = {token_q, step_toks[i]};
   endfunction

   // ---------------- source generation ----------------
   task automatic add_byte(input logic [7:0] c);
      src_item_type it;
      it.ch = c;
      it.eos = 0;
      source_q = {source_q, it};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_end();
      src_item_type it;
      it.ch = 8'($urandom_range(0, 255));
      it.eos = 1;
      source_q = {source_q, it};
   endtask

   task automatic add_fragment();
      string alnum;
      string ops[12];
      string seps[7];
      int    pick;
      int    n;
      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      ops = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "/", "(", "*", ".;,"};
      seps = '{" ", "\n", "", "\t", "\r", "(", " "};
      pick = $urandom_range(0, 99);
      if (pick < 15) add_text(keywords[$urandom_range(0, 15)]);
      else if (pick < 30) begin
         // identifiers, some of them keywords alone or keywords with a tail
         if ($urandom_range(0, 2) == 0) add_text(keywords[$urandom_range(0, 15)]);
         else add_byte(alnum[$urandom_range(0, 52)]);
         n = $urandom_range(0, 8);
         repeat (n) add_byte(alnum[$urandom_range(0, 62)]);
      end else if (pick < 45) begin
         repeat ($urandom_range(1, 3)) add_byte(8'("0") + 8'($urandom_range(0, 9)));
         case ($urandom_range(0, 2))
            0: begin
               add_byte(".");
               repeat ($urandom_range(1, 2)) add_byte(8'("0") + 8'($urandom_range(0, 9)));
            end
            1: add_byte(".");
            default: ;
         endcase
      end else if (pick < 55) begin
         add_byte("\"");
         repeat ($urandom_range(0, 5))
            add_byte(($urandom_range(0, 4) == 0) ? 8'("\n") : alnum[$urandom_range(0, 62)]);
         add_byte("\"");
      end else if (pick < 60) begin
         add_text("//");
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 126)));
         add_byte("\n");
      end else if (pick < 66) begin
         add_text("/*");
         repeat ($urandom_range(0, 4)) add_byte(($urandom_range(0, 2) == 0) ? 8'("*") :
            ($urandom_range(0, 3) == 0) ? 8'("\n") : 8'($urandom_range(32, 126)));
         add_text("*/");
      end else if (pick < 80) add_text(ops[$urandom_range(0, 11)]);
      else if (pick < 90) add_byte(8'($urandom_range(0, 255)));
      else add_end();
      add_text(seps[$urandom_range(0, 6)]);
   endtask

   // ---------------- clock, reset, stimulus ----------------
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_ch = 0;
      req_end_of_source = 0;
      rsp_ready = 0;

      // directed: punctuators, operator pairs, numbers, comments, odd bytes, strings
      add_text("(){},.-+;*");
      add_text("!=!<=>>= ==/");
      add_text("1.5 2.x");
      add_text("//c\n/**/");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_text("\"a\nb\"@");
      add_end();
      // end flushes: dangling "7.", open string, open block comment, pending "<"
      add_text("7.");
      add_end();
      add_text("\"ab");
      add_end();
      add_text("/*x");
      add_end();
      add_text("dPrint abcdefgh<");
      add_end();
      while (source_q.size() < 430) add_fragment();
      add_end();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      wait (source_q.size() == 0 && !req_valid);
      wait (token_q.size() == 0);
      repeat (20) @(posedge clock);
      stim_done = 1;
      $display("scanned %0d source items, checked %0d tokens (%0d eof, %0d error)",
               bytes_taken, tokens_seen, eof_seen, errors_seen);
      if (fails == 0 && token_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // no idling anywhere while this window of transfers goes by
   function automatic bit quiet_window();
      return bytes_taken >= 300 && bytes_taken < 380;
   endfunction

   // ---------------- driver ----------------
   always @(negedge clock) begin
      src_item_type it;
      logic      nxt_valid;
      logic [7:0] nxt_ch;
      logic      nxt_eos;
      if (!reset) begin
         nxt_valid = req_valid;
         nxt_ch = req_ch;
         nxt_eos = req_end_of_source;
         if (!req_valid || byte_taken) begin
            byte_taken = 0;
            nxt_valid = 0;
            // one pause where the sender lets the whole pipe drain
            if (source_q.size() > 0 && !(bytes_taken == PAUSE_AT && token_q.size() != 0)
                && (quiet_window() || $urandom_range(0, 99) >= 25)) begin
               it = source_q.pop_front();
               nxt_valid = 1;
               nxt_ch = it.ch;
               nxt_eos = it.eos;
            end
         end
         req_valid <= nxt_valid;
         req_ch <= nxt_ch;
         req_end_of_source <= nxt_eos;
      end
   end

   // ---------------- receiver ----------------
   int  hold_count = 0;
   bit  hold_done = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && tokens_seen >= 80) begin
            // long hold-off so the token queue fills and req_ready drops
            rsp_ready <= 0;
            hold_count++;
            if (hold_count >= HOLDOFF_CYCLES) hold_done = 1;
         end else
            rsp_ready <= quiet_window() || ($urandom_range(0, 99) >= 25);
      end
   end

   // ---------------- monitors ----------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_tokens(req_ch, req_end_of_source);
         byte_taken = 1;
         bytes_taken++;
      end
   end

   always @(posedge clock) begin
      exp_token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         tokens_seen++;
         if (rsp_token_kind == K_EOF) eof_seen++;
         if (rsp_token_kind == K_ERROR) errors_seen++;
         if (token_q.size() == 0) begin
            fails++;
            $display("%0t: unexpected token kind %0d at %0d", $time, rsp_token_kind,
                     rsp_start_offset);
         end else begin
            want = token_q.pop_front();
            if (rsp_token_kind !== want.kind) begin
               fails++;
               $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                        rsp_token_kind);
            end
            if (rsp_start_offset !== want.start) begin
               fails++;
               $display("%0t: start expected %0d actual %0d", $time, want.start,
                        rsp_start_offset);
            end
            if (rsp_text_length !== want.len) begin
               fails++;
               $display("%0t: length expected %0d actual %0d", $time, want.len,
                        rsp_text_length);
            end
            if (rsp_line_number !== want.line) begin
               fails++;
               $display("%0t: line expected %0d actual %0d", $time, want.line,
                        rsp_line_number);
            end
            if (rsp_error_code !== want.err) begin
               fails++;
               $display("%0t: error code expected %0d actual %0d", $time, want.err,
                        rsp_error_code);
            end
            if (rsp_last_of_run !== want.last) begin
               fails++;
               $display("%0t: last flag expected %0d actual %0d", $time, want.last,
                        rsp_last_of_run);
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   int stall_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
